// ----- rtl/dq_pkg.sv -----
// package: field widths, operation codes and shared types of the double-ended queue
`default_nettype none

package dq_pkg;

  localparam int unsigned KIND_W  = 3;
  localparam int unsigned INDEX_W = 10;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned COUNT_W = 11;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_READ_IDX   = 3'd2,
    KIND_WRITE_IDX  = 3'd3,
    KIND_FRONT      = 3'd4,
    KIND_BACK       = 3'd5,
    KIND_SIZE       = 3'd6
  } dq_kind_e;

  // result status that travels with a transaction while its read is in flight
  typedef struct packed {
    logic               rd;
    logic               err;
    logic [COUNT_W-1:0] cnt;
    logic               empty;
  } dq_info_t;

endpackage

`default_nettype wire

// ----- rtl/dq_if.sv -----
// interfaces: operation channel and result channel
`default_nettype none

interface dq_in_if import dq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [INDEX_W-1:0] index;
  logic [DATA_W-1:0]  data_in;

  modport source (output valid, output kind, output index, output data_in, input ready);
  modport sink   (input valid, input kind, input index, input data_in, output ready);
endinterface

interface dq_out_if import dq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [DATA_W-1:0]  data_out;
  logic               error;
  logic [COUNT_W-1:0] count_out;
  logic               is_empty;

  modport source (output valid, output data_out, output error, output count_out,
                  output is_empty, input ready);
  modport sink   (input valid, input data_out, input error, input count_out,
                  input is_empty, output ready);
endinterface

`default_nettype wire

// ----- rtl/dq_ram.sv -----
// generic single-port ram with registered read
`default_nettype none

module dq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/dq_ctrl.sv -----
// head pointer, element count, operation decode and ring address generation
`default_nettype none

module dq_ctrl import dq_pkg::*; #(
  parameter int unsigned DEPTH      = 1024,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       acc_i,
  input  wire logic [KIND_W-1:0]          kind_i,
  input  wire logic [INDEX_W-1:0]         index_i,
  input  wire logic [DATA_W-1:0]          data_i,
  output logic                            mem_en_o,
  output logic                            mem_we_o,
  output logic [$clog2(DEPTH)-1:0]        mem_addr_o,
  output logic [((DATA_WIDTH < DATA_W) ? DATA_WIDTH : DATA_W)-1:0] mem_wdata_o,
  output dq_info_t                        info_o
);

  localparam int unsigned MEM_W = (DATA_WIDTH < DATA_W) ? DATA_WIDTH : DATA_W;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W = PTR_W + 1;
  localparam int unsigned CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
  localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
  localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(DEPTH - 1);

  logic [PTR_W-1:0] head_q, head_d, head_dec;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [SUM_W-1:0] off, ring_sum, ring_pos;
  logic             full, empty, idx_ok;
  logic             en, we, rd, err;

  assign full     = (cnt_q == DEPTH_C);
  assign empty    = (cnt_q == '0);
  assign idx_ok   = (CMP_W'(index_i) < CMP_W'(cnt_q));
  assign head_dec = (head_q == '0) ? LAST_P : head_q - 1'b1;

  // head plus offset stays below twice the depth, so one subtract wraps it
  assign ring_sum = {1'b0, head_q} + off;
  assign ring_pos = (ring_sum >= DEPTH_S) ? ring_sum - DEPTH_S : ring_sum;

  // push front writes just below the old head, everything else goes through the ring offset
  assign mem_addr_o = (kind_i == KIND_PUSH_FRONT) ? head_dec : ring_pos[PTR_W-1:0];

  always_comb begin
    off        = '0;
    head_d     = head_q;
    cnt_d      = cnt_q;
    en         = 1'b0;
    we         = 1'b0;
    rd         = 1'b0;
    err        = 1'b0;
    unique case (kind_i)
      KIND_PUSH_FRONT: begin
        if (full) begin
          err = 1'b1;
        end else begin
          head_d = head_dec;
          cnt_d  = cnt_q + 1'b1;
          en     = 1'b1;
          we     = 1'b1;
        end
      end
      KIND_PUSH_BACK: begin
        off = SUM_W'(cnt_q);
        if (full) begin
          err = 1'b1;
        end else begin
          cnt_d = cnt_q + 1'b1;
          en    = 1'b1;
          we    = 1'b1;
        end
      end
      KIND_READ_IDX: begin
        off = SUM_W'(index_i);
        if (!idx_ok) begin
          err = 1'b1;
        end else begin
          en = 1'b1;
          rd = 1'b1;
        end
      end
      KIND_WRITE_IDX: begin
        off = SUM_W'(index_i);
        if (!idx_ok) begin
          err = 1'b1;
        end else begin
          en = 1'b1;
          we = 1'b1;
        end
      end
      KIND_FRONT: begin
        if (empty) begin
          err = 1'b1;
        end else begin
          en = 1'b1;
          rd = 1'b1;
        end
      end
      KIND_BACK: begin
        off = SUM_W'(cnt_q - 1'b1);
        if (empty) begin
          err = 1'b1;
        end else begin
          en = 1'b1;
          rd = 1'b1;
        end
      end
      default: begin
        // size query and the unused code change nothing
      end
    endcase
  end

  assign mem_en_o     = acc_i && en;
  assign mem_we_o     = we;
  assign mem_wdata_o  = MEM_W'(data_i);
  assign info_o.rd    = rd;
  assign info_o.err   = err;
  assign info_o.cnt   = COUNT_W'(cnt_d);
  assign info_o.empty = (cnt_d == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      cnt_q  <= '0;
    end else if (acc_i) begin
      head_q <= head_d;
      cnt_q  <= cnt_d;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DEPTH_C)
    else $error("element count above depth");

  a_err_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i && err |=> (cnt_q == $past(cnt_q)) && (head_q == $past(head_q)))
    else $error("refused operation changed the queue");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i && we && !err && ((kind_i == KIND_PUSH_FRONT) || (kind_i == KIND_PUSH_BACK))
    |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("push did not grow the count");

endmodule

`default_nettype wire

// ----- rtl/double_ended_queue_top.sv -----
// top level: double-ended queue on a ring buffer in one synchronous ram
//
//  channel   dir   handshake      payload
//  in_if     in    valid/ready    kind, index, data_in
//  out_if    out   valid/ready    data_out, error, count_out, is_empty
//
// one transaction per cycle sustained while out_if.ready holds; an accepted
//   transaction's result passes the ram read, then the output register
// head pointer and count update at acceptance, so the next transaction always
//   sees the finished state; the single ram port takes one access per cycle
// reset clears pointer, count and valids; storage stays undefined, no clearing pass
// a stalled result holds the output register, the in-flight slot behind it fills,
//   and then in_if.ready drops until out_if.ready returns
`default_nettype none

module double_ended_queue_top import dq_pkg::*; #(
  parameter int unsigned DEPTH      = 1024,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  dq_in_if.sink     in_if,
  dq_out_if.source  out_if
);

  localparam int unsigned MEM_W = (DATA_WIDTH < DATA_W) ? DATA_WIDTH : DATA_W;
  localparam int unsigned PTR_W = $clog2(DEPTH);

  logic             acc;
  logic             mem_en, mem_we;
  logic [PTR_W-1:0] mem_addr;
  logic [MEM_W-1:0] mem_wdata, mem_rdata;
  dq_info_t         info;

  // slot for the transaction whose ram read is in flight
  logic             s1_valid_q;
  dq_info_t         s1_info_q;
  logic             s1_move;

  // output register
  logic               out_valid_q;
  logic [DATA_W-1:0]  out_data_q;
  logic               out_err_q;
  logic [COUNT_W-1:0] out_cnt_q;
  logic               out_empty_q;

  assign s1_move     = s1_valid_q && (!out_valid_q || out_if.ready);
  assign in_if.ready = !s1_valid_q || s1_move;
  assign acc         = in_if.valid && in_if.ready;

  dq_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (acc),
    .kind_i      (in_if.kind),
    .index_i     (in_if.index),
    .data_i      (in_if.data_in),
    .mem_en_o    (mem_en),
    .mem_we_o    (mem_we),
    .mem_addr_o  (mem_addr),
    .mem_wdata_o (mem_wdata),
    .info_o      (info)
  );

  // read data holds until the next read, which covers a stalled slot
  dq_ram #(
    .WIDTH (MEM_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (mem_en),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_move) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_info_q <= info;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_move) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // only error-free reads return stored data, everything else answers zero
  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_data_q  <= s1_info_q.rd ? DATA_W'(mem_rdata) : '0;
      out_err_q   <= s1_info_q.err;
      out_cnt_q   <= s1_info_q.cnt;
      out_empty_q <= s1_info_q.empty;
    end
  end

  assign out_if.valid     = out_valid_q;
  assign out_if.data_out  = out_data_q;
  assign out_if.error     = out_err_q;
  assign out_if.count_out = out_cnt_q;
  assign out_if.is_empty  = out_empty_q;

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_valid_q && !out_if.ready |-> !in_if.ready)
    else $error("input taken while the result path is full");

  a_read_issues_ram: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && info.rd |-> mem_en && !mem_we)
    else $error("accepted read did not access the ram");

  a_accept_fills_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> s1_valid_q)
    else $error("accepted transaction lost before the output register");

endmodule

`default_nettype wire
